// ----- hdl/tsms_pkg.sv -----
package tsms_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE       = 3'd0,
    CMD_FAST_CONNECT = 3'd1,
    CMD_FAST_SEND    = 3'd2,
    CMD_FAST_RELEASE = 3'd3,
    CMD_TCP_CONNECT  = 3'd4,
    CMD_TCP_RECV     = 3'd5,
    CMD_TCP_FIN      = 3'd6
  } cmd_t;

  localparam logic REG_COUNT_THRESHOLD = 1'b0;
  localparam logic REG_SEND_RATIO      = 1'b1;

  localparam logic [15:0] THRESHOLD_RESET = 16'd1024;
  localparam logic [7:0]  RATIO_RESET     = 8'd80;

  localparam logic [5:0]  FAST_FAMILY   = 6'd43;
  localparam logic [5:0]  FAMILY_V4     = 6'd2;
  localparam logic [5:0]  FAMILY_V6     = 6'd10;
  localparam logic [15:0] STREAM_TYPE   = 16'd1;
  localparam logic [7:0]  PROTO_DEFAULT = 8'd0;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  FAST_PROTO_V4 = 8'd0;
  localparam logic [7:0]  FAST_PROTO_V6 = 8'd1;

  typedef struct packed {
    logic steering_on;
    logic mode_flipped;
  } mode_status_t;

  typedef struct packed {
    logic       rewritten;
    logic [5:0] family;
    logic [7:0] protocol;
  } create_res_t;

endpackage

// ----- hdl/tsms_in_if.sv -----
interface tsms_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic        kernel_caller;
  logic [5:0]  family;
  logic [15:0] sock_type;
  logic [7:0]  protocol;

  modport source (output valid, cmd, kernel_caller, family, sock_type, protocol,
                  input ready);
  modport sink (input valid, cmd, kernel_caller, family, sock_type, protocol,
                output ready);
endinterface

// ----- hdl/tsms_out_if.sv -----
interface tsms_out_if;
  logic       valid;
  logic       ready;
  logic       steering_on;
  logic       mode_flipped;
  logic       rewritten;
  logic [5:0] out_family;
  logic [7:0] out_protocol;

  modport source (output valid, steering_on, mode_flipped, rewritten, out_family,
                  out_protocol, input ready);
  modport sink (input valid, steering_on, mode_flipped, rewritten, out_family,
                out_protocol, output ready);
endinterface

// ----- hdl/tcp_smc_mode_steering.sv -----
// channel  | dir | handshake    | payload
// in       | in  | valid/ready  | cmd, kernel_caller, family, sock_type, protocol
// out      | out | valid/ready  | steering_on, mode_flipped, rewritten, out_family,
//          |     |              | out_protocol
// wr_*     | in  | wr_en only   | wr_index (0 count_threshold, 1 send_ratio), wr_data
//
// one item per cycle sustained while out is not stalled; an accepted item passes the input
// register, then counter update and result register in one pass, before out.valid rises
// synchronous active-high reset: steering on, counters zero, config to defaults
// a stall on out holds the result register and backs up into the input register;
// in.ready drops only when both stages are full and out is stalled
module tcp_smc_mode_steering
  import tsms_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  tsms_in_if.sink     in,
  tsms_out_if.source  out,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data
);

  logic [15:0] count_threshold;
  logic [7:0]  send_ratio;

  logic        s1_valid;
  logic [2:0]  s1_cmd;
  logic        s1_kernel_caller;
  logic [5:0]  s1_family;
  logic [15:0] s1_sock_type;
  logic [7:0]  s1_protocol;

  logic         s2_valid;
  mode_status_t s2_status;
  create_res_t  s2_create;

  logic         adv2;
  logic         step;
  logic         steer_mode;
  mode_status_t status;
  create_res_t  create_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_threshold <= THRESHOLD_RESET;
      send_ratio      <= RATIO_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_COUNT_THRESHOLD: count_threshold <= wr_data;
        REG_SEND_RATIO:      send_ratio      <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign adv2     = !s2_valid || out.ready;
  assign step     = s1_valid && adv2;
  assign in.ready = !s1_valid || adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= (s1_valid && !adv2) || in.valid;
      if (adv2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      s1_cmd           <= in.cmd;
      s1_kernel_caller <= in.kernel_caller;
      s1_family        <= in.family;
      s1_sock_type     <= in.sock_type;
      s1_protocol      <= in.protocol;
    end
    if (step) begin
      s2_status <= status;
      s2_create <= create_res;
    end
  end

  tsms_counters #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_counters (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .cmd             (s1_cmd),
    .count_threshold (count_threshold),
    .send_ratio      (send_ratio),
    .steer_mode      (steer_mode),
    .status          (status)
  );

  tsms_create u_create (
    .steer_mode    (steer_mode),
    .cmd           (s1_cmd),
    .kernel_caller (s1_kernel_caller),
    .family        (s1_family),
    .sock_type     (s1_sock_type),
    .protocol      (s1_protocol),
    .res           (create_res)
  );

  assign out.valid        = s2_valid;
  assign out.steering_on  = s2_status.steering_on;
  assign out.mode_flipped = s2_status.mode_flipped;
  assign out.rewritten    = s2_create.rewritten;
  assign out.out_family   = s2_create.family;
  assign out.out_protocol = s2_create.protocol;

  // mode only moves when an item passes through the update stage
  a_mode_moves_on_step: assert property (@(posedge clk) disable iff (rst)
    (steer_mode != $past(steer_mode)) |-> $past(step))
    else $error("steering mode changed without an item");

  // flipped flag in the result register matches the mode register change
  a_flip_matches_mode: assert property (@(posedge clk) disable iff (rst)
    step |=> (s2_status.mode_flipped == (steer_mode != $past(steer_mode))))
    else $error("mode_flipped disagrees with mode register");

  // a rewrite only happens with steering on, and a create never flips the mode
  a_rewrite_needs_steering: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_create.rewritten) |->
      (s2_status.steering_on && !s2_status.mode_flipped))
    else $error("rewritten item without steering on");

endmodule

// ----- hdl/tsms_create.sv -----
module tsms_create
  import tsms_pkg::*;
(
  input  logic        steer_mode,
  input  logic [2:0]  cmd,
  input  logic        kernel_caller,
  input  logic [5:0]  family,
  input  logic [15:0] sock_type,
  input  logic [7:0]  protocol,
  output create_res_t res
);

  logic fam_ok;
  logic proto_ok;
  logic hit;

  assign fam_ok   = (family == FAMILY_V4) || (family == FAMILY_V6);
  assign proto_ok = (protocol == PROTO_DEFAULT) || (protocol == PROTO_TCP);
  assign hit      = (cmd == CMD_CREATE) && steer_mode && !kernel_caller && fam_ok &&
                    (sock_type == STREAM_TYPE) && proto_ok;

  always_comb begin
    res.rewritten = hit;
    res.family    = family;
    res.protocol  = protocol;
    if (hit) begin
      res.family   = FAST_FAMILY;
      res.protocol = (family == FAMILY_V4) ? FAST_PROTO_V4 : FAST_PROTO_V6;
    end
  end

endmodule

// ----- hdl/tsms_counters.sv -----
module tsms_counters
  import tsms_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [2:0]   cmd,
  input  logic [15:0]  count_threshold,
  input  logic [7:0]   send_ratio,
  output logic         steer_mode,
  output mode_status_t status
);

  localparam int PW = COUNT_WIDTH + 8;

  logic [COUNT_WIDTH-1:0] fast_conn, fast_send, fast_rel;
  logic [COUNT_WIDTH-1:0] tcp_conn, tcp_recv, tcp_fin;

  logic [COUNT_WIDTH-1:0] act_conn, act_send, act_rel;
  logic [COUNT_WIDTH-1:0] conn_next, send_next, rel_next;
  logic [COUNT_WIDTH-1:0] rel_inc, thr_ext;
  logic [PW-1:0]          prod, half_ext;
  logic                   is_conn, is_send, is_rel, decide, flip, mode_next;

  always_comb begin
    act_conn = steer_mode ? fast_conn : tcp_conn;
    act_send = steer_mode ? fast_send : tcp_recv;
    act_rel  = steer_mode ? fast_rel  : tcp_fin;

    is_conn = (cmd == (steer_mode ? CMD_FAST_CONNECT : CMD_TCP_CONNECT));
    is_send = (cmd == (steer_mode ? CMD_FAST_SEND    : CMD_TCP_RECV));
    is_rel  = (cmd == (steer_mode ? CMD_FAST_RELEASE : CMD_TCP_FIN));

    rel_inc  = (&act_rel) ? act_rel : act_rel + 1'b1;
    thr_ext  = COUNT_WIDTH'(count_threshold);
    // exact product, no overflow at any counter width
    prod     = {8'b0, act_conn} * {{COUNT_WIDTH{1'b0}}, send_ratio};
    half_ext = {8'b0, (act_send >> 1)};

    decide = is_rel && (act_conn > thr_ext) && (rel_inc >= thr_ext);
    flip   = decide && (steer_mode ? (prod > half_ext) : (prod < half_ext));

    conn_next = act_conn;
    send_next = act_send;
    rel_next  = act_rel;
    if (decide) begin
      conn_next = '0;
      send_next = '0;
      rel_next  = '0;
    end else if (is_conn) begin
      conn_next = (&act_conn) ? act_conn : act_conn + 1'b1;
    end else if (is_send) begin
      send_next = (&act_send) ? act_send : act_send + 1'b1;
    end else if (is_rel) begin
      rel_next = rel_inc;
    end

    mode_next           = steer_mode ^ flip;
    status.steering_on  = mode_next;
    status.mode_flipped = flip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_mode <= 1'b1;
      fast_conn  <= '0;
      fast_send  <= '0;
      fast_rel   <= '0;
      tcp_conn   <= '0;
      tcp_recv   <= '0;
      tcp_fin    <= '0;
    end else if (step) begin
      steer_mode <= mode_next;
      // only the active mode's counters move
      if (steer_mode) begin
        fast_conn <= conn_next;
        fast_send <= send_next;
        fast_rel  <= rel_next;
      end else begin
        tcp_conn <= conn_next;
        tcp_recv <= send_next;
        tcp_fin  <= rel_next;
      end
    end
  end

endmodule

// ----- sim/tsms_checker.sv -----
`timescale 1ns / 1ps
module tsms_checker
  import tsms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tsms_in_if          in_ch,
  tsms_out_if         out_ch,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  output int          errors,
  output int          pending,
  output int          checked,
  output int          flips,
  output int          rewrites,
  output logic        steering
);

  localparam int CW = 32;

  typedef struct packed {
    mode_status_t status;
    create_res_t  create;
  } event_res_t;

  logic [15:0]   threshold;
  logic [7:0]    ratio;
  logic          mode;
  logic [CW-1:0] fast_conn, fast_send, fast_rel;
  logic [CW-1:0] tcp_conn, tcp_recv, tcp_fin;
  event_res_t    awaited_results[$];
  int            err_cnt, n_pend, n_checked, n_flips, n_rew;

  assign errors   = err_cnt;
  assign pending  = n_pend;
  assign checked  = n_checked;
  assign flips    = n_flips;
  assign rewrites = n_rew;
  assign steering = mode;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // apply one connection event to the mode state and work out its result
  task automatic steer_event(input logic [2:0] cmd, input logic kern, input logic [5:0] fam,
                             input logic [15:0] typ, input logic [7:0] proto,
                             output event_res_t res);
    logic       prior;
    logic [47:0] prod;
    prior = mode;
    res.create.rewritten = 1'b0;
    res.create.family    = fam;
    res.create.protocol  = proto;
    case (cmd)
      CMD_CREATE: begin
        if (mode && !kern && (fam == FAMILY_V4 || fam == FAMILY_V6) && typ == STREAM_TYPE &&
            (proto == PROTO_DEFAULT || proto == PROTO_TCP)) begin
          res.create.rewritten = 1'b1;
          res.create.family    = FAST_FAMILY;
          res.create.protocol  = (fam == FAMILY_V4) ? FAST_PROTO_V4 : FAST_PROTO_V6;
        end
      end
      CMD_FAST_CONNECT: if (mode) fast_conn = bump(fast_conn);
      CMD_FAST_SEND:    if (mode) fast_send = bump(fast_send);
      CMD_FAST_RELEASE: begin
        if (mode) begin
          fast_rel = bump(fast_rel);
          if (fast_conn > threshold && fast_rel >= threshold) begin
            prod = 48'(fast_conn) * 48'(ratio);
            if (prod > 48'(fast_send >> 1)) mode = 1'b0;
            fast_conn = '0;
            fast_send = '0;
            fast_rel  = '0;
          end
        end
      end
      CMD_TCP_CONNECT: if (!mode) tcp_conn = bump(tcp_conn);
      CMD_TCP_RECV:    if (!mode) tcp_recv = bump(tcp_recv);
      CMD_TCP_FIN: begin
        if (!mode) begin
          tcp_fin = bump(tcp_fin);
          if (tcp_conn > threshold && tcp_fin >= threshold) begin
            prod = 48'(tcp_conn) * 48'(ratio);
            if (prod < 48'(tcp_recv >> 1)) mode = 1'b1;
            tcp_conn = '0;
            tcp_recv = '0;
            tcp_fin  = '0;
          end
        end
      end
      default: ;
    endcase
    res.status.steering_on  = mode;
    res.status.mode_flipped = (mode != prior);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
    if (seen !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    event_res_t res;
    if (rst) begin
      threshold = THRESHOLD_RESET;
      ratio     = RATIO_RESET;
      mode      = 1'b1;
      fast_conn = '0;
      fast_send = '0;
      fast_rel  = '0;
      tcp_conn  = '0;
      tcp_recv  = '0;
      tcp_fin   = '0;
      awaited_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          err_cnt++;
          $display({"%0t: result with no item outstanding, expected none got ",
                    "on=%0b flip=%0b rew=%0b fam=%0d proto=%0d"},
                   $time, out_ch.steering_on, out_ch.mode_flipped, out_ch.rewritten,
                   out_ch.out_family, out_ch.out_protocol);
        end else begin
          res = awaited_results.pop_front();
          n_checked++;
          check_field("steering_on", 8'(res.status.steering_on), 8'(out_ch.steering_on));
          check_field("mode_flipped", 8'(res.status.mode_flipped), 8'(out_ch.mode_flipped));
          check_field("rewritten", 8'(res.create.rewritten), 8'(out_ch.rewritten));
          check_field("out_family", 8'(res.create.family), 8'(out_ch.out_family));
          check_field("out_protocol", res.create.protocol, out_ch.out_protocol);
        end
      end
      if (wr_en) begin
        if (wr_index == REG_COUNT_THRESHOLD) threshold = wr_data;
        else ratio = wr_data[7:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        steer_event(in_ch.cmd, in_ch.kernel_caller, in_ch.family, in_ch.sock_type,
                    in_ch.protocol, res);
        awaited_results.push_back(res);
        if (res.status.mode_flipped) n_flips++;
        if (res.create.rewritten) n_rew++;
      end
    end
    n_pend = awaited_results.size();
  end

endmodule

// ----- sim/tcp_smc_mode_steering_tb.sv -----
`timescale 1ns / 1ps
module tcp_smc_mode_steering_tb;
  import tsms_pkg::*;

  localparam logic [2:0] CMD_UNUSED  = 3'd7;
  localparam int         IDLE_LIMIT  = 3000;
  localparam int         HOLD_CYCLES = 80;
  localparam int         ITEM_TARGET = 1750;
  localparam int         N_PLAN      = 8;
  localparam logic [15:0] THR_PLAN [N_PLAN] =
    '{16'd1, 16'd2, 16'd65535, 16'd4, 16'd1, 16'd3, 16'd8, THRESHOLD_RESET};
  localparam logic [7:0] RATIO_PLAN [N_PLAN] =
    '{8'd1, 8'd2, 8'd255, 8'd3, 8'd255, 8'd1, 8'd4, RATIO_RESET};

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic        wr_index;
  logic [15:0] wr_data;
  int          errors, pending, checked, flips, rewrites;
  logic        steering;
  bit          src_idle, snk_idle, hold_results;
  int          n_items, n_settings, quiet_cycles;
  logic [15:0] thr_cur;
  logic [7:0]  ratio_cur;

  tsms_in_if  in_ch ();
  tsms_out_if out_ch ();

  tcp_smc_mode_steering #(.COUNT_WIDTH(32)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in       (in_ch),
    .out      (out_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  tsms_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked),
    .flips    (flips),
    .rewrites (rewrites),
    .steering (steering)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // valid stays high after an accept so back-to-back items never toggle it in one step
  task automatic send_item(input logic [2:0] cmd, input logic kern, input logic [5:0] fam,
                           input logic [15:0] typ, input logic [7:0] proto);
    int gap;
    gap = src_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= cmd;
    in_ch.kernel_caller <= kern;
    in_ch.family        <= fam;
    in_ch.sock_type     <= typ;
    in_ch.protocol      <= proto;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
  endtask

  task automatic send_event(input logic [2:0] cmd);
    send_item(cmd, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
              16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endtask

  // creates mostly close to the rewrite rule, with one or more conditions broken now and then
  task automatic send_create();
    logic        kern;
    logic [5:0]  fam;
    logic [15:0] typ;
    logic [7:0]  proto;
    kern = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 2))
      0:       fam = FAMILY_V4;
      1:       fam = FAMILY_V6;
      default: fam = 6'($urandom_range(0, 63));
    endcase
    typ = ($urandom_range(0, 2) != 0) ? STREAM_TYPE : 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 2))
      0:       proto = PROTO_DEFAULT;
      1:       proto = PROTO_TCP;
      default: proto = 8'($urandom_range(0, 255));
    endcase
    send_item(CMD_CREATE, kern, fam, typ, proto);
  endtask

  task automatic send_noise();
    logic [2:0] cmd;
    cmd = 3'($urandom_range(0, 7));
    if (cmd == CMD_CREATE) send_create();
    else send_event(cmd);
  endtask

  // one connection burst for a mode: enough connects to pass the threshold, an activity
  // count around the decision boundary or tiny, then releases to the threshold or one past it
  task automatic run_session(input bit fast);
    int conns, acts, rels, bound;
    conns = int'(thr_cur) + 1 + $urandom_range(0, 2);
    bound = 2 * conns * int'(ratio_cur);
    if (bound <= 120 && $urandom_range(0, 2) != 0) acts = bound - 1 + $urandom_range(0, 3);
    else acts = $urandom_range(0, 4);
    rels = int'(thr_cur) + $urandom_range(0, 1);
    while (conns + acts > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else if (acts == 0 || (conns > 0 && $urandom_range(0, conns + acts - 1) < conns)) begin
        send_event(fast ? CMD_FAST_CONNECT : CMD_TCP_CONNECT);
        conns--;
      end else begin
        send_event(fast ? CMD_FAST_SEND : CMD_TCP_RECV);
        acts--;
      end
    end
    repeat (rels) send_event(fast ? CMD_FAST_RELEASE : CMD_TCP_FIN);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] thr, input logic [7:0] ratio);
    wr_en    <= 1'b1;
    wr_index <= REG_COUNT_THRESHOLD;
    wr_data  <= thr;
    @(posedge clk);
    wr_index <= REG_SEND_RATIO;
    wr_data  <= {8'd0, ratio};
    @(posedge clk);
    wr_en     <= 1'b0;
    thr_cur   = thr;
    ratio_cur = ratio;
    n_settings++;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = snk_idle ? $urandom_range(0, 12) : 0;
      if (hold_results) begin
        gap = HOLD_CYCLES;
        hold_results = 1'b0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || wr_en || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    longint phase_end;
    rst                 <= 1'b1;
    wr_en               <= 1'b0;
    wr_index            <= REG_COUNT_THRESHOLD;
    wr_data             <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.cmd           <= CMD_CREATE;
    in_ch.kernel_caller <= 1'b0;
    in_ch.family        <= '0;
    in_ch.sock_type     <= '0;
    in_ch.protocol      <= '0;
    src_idle     = 1'b1;
    snk_idle     = 1'b1;
    hold_results = 1'b0;
    n_items      = 0;
    n_settings   = 0;
    thr_cur      = THRESHOLD_RESET;
    ratio_cur    = RATIO_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // create rule at reset settings, steering on
    send_item(CMD_CREATE, 1'b0, FAMILY_V4, STREAM_TYPE, PROTO_DEFAULT);
    send_item(CMD_CREATE, 1'b0, FAMILY_V6, STREAM_TYPE, PROTO_TCP);
    send_item(CMD_CREATE, 1'b0, FAMILY_V6, STREAM_TYPE, PROTO_DEFAULT);
    send_item(CMD_CREATE, 1'b1, FAMILY_V4, STREAM_TYPE, PROTO_DEFAULT);
    send_item(CMD_CREATE, 1'b0, FAMILY_V4, 16'd0, PROTO_TCP);
    send_item(CMD_CREATE, 1'b0, '1, '1, '1);
    send_item(CMD_CREATE, 1'b0, FAMILY_V6, STREAM_TYPE, PROTO_DEFAULT + 8'd1);
    send_item(CMD_UNUSED, 1'b1, '1, '1, '1);
    for (int c = CMD_FAST_CONNECT; c <= CMD_TCP_FIN; c++) begin
      send_item(3'(c), 1'b1, '1, '1, '1);
    end

    // smallest threshold and ratio: flip off, create while off, flip back on
    wait_idle();
    write_config(16'd1, 8'd1);
    send_item(CMD_FAST_CONNECT, 1'b0, '0, '0, '0);
    send_item(CMD_FAST_CONNECT, 1'b0, '0, '0, '0);
    send_item(CMD_FAST_RELEASE, 1'b0, '0, '0, '0);
    send_item(CMD_CREATE, 1'b0, FAMILY_V4, STREAM_TYPE, PROTO_TCP);
    send_item(CMD_TCP_CONNECT, 1'b0, '0, '0, '0);
    send_item(CMD_TCP_CONNECT, 1'b0, '0, '0, '0);
    repeat (6) send_item(CMD_TCP_RECV, 1'b0, '0, '0, '0);
    send_item(CMD_TCP_FIN, 1'b0, '0, '0, '0);

    for (int p = 0; n_items < ITEM_TARGET; p++) begin
      wait_idle();
      write_config(THR_PLAN[p % N_PLAN], RATIO_PLAN[p % N_PLAN]);
      src_idle  = (p % 3) != 2;
      snk_idle  = (p % 4) != 1;
      phase_end = n_items + 200 + $urandom_range(0, 100);
      if (p == 2) hold_results = 1'b1;
      if (p == 1) begin
        // sender stops mid-phase until the pipe drains
        repeat (40) send_noise();
        wait_idle();
      end
      while (n_items < phase_end) begin
        if (thr_cur <= 16'd8 && $urandom_range(0, 4) != 0)
          run_session(($urandom_range(0, 9) == 0) ? !steering : steering);
        else
          repeat ($urandom_range(1, 10)) send_noise();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("tb: run covered %0d items under %0d register settings, %0d results checked",
             n_items, n_settings, checked);
    $display("tb: %0d steering flips and %0d rewritten creates predicted", flips, rewrites);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tsms_pkg.sv
hdl/tsms_in_if.sv
hdl/tsms_out_if.sv
hdl/tsms_create.sv
hdl/tsms_counters.sv
hdl/tcp_smc_mode_steering.sv
sim/tsms_checker.sv
sim/tcp_smc_mode_steering_tb.sv
